### hdl/blg_pkg.sv
// Shared types and constants of the binomial logit GLM element.
// No dependencies; the design files other than blg_checker refer to it by scoped names.
package blg_pkg;

    // Exponential: six Horner steps of two stages each, then eight squarings.
    localparam int unsigned EXP_STEPS = 6;
    localparam int unsigned SQ_STEPS  = 8;
    localparam int unsigned LAT_EXP   = 2 * EXP_STEPS + SQ_STEPS;

    // Reciprocal divider: one quotient bit per stage.
    localparam int unsigned DIV_BITS = 31;

    // Base-two logarithm: one normalising stage, then one stage per fraction bit.
    localparam int unsigned LG_FRAC = 26;
    localparam int unsigned LAT_LG  = LG_FRAC + 1;

    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
    localparam logic [15:0] ONE_Q15 = 16'h8000;
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;

    // One observation after classification.
    typedef struct packed {
        logic [15:0] mag;   // |eta|
        logic        neg;   // eta below zero
        logic [15:0] y;     // proportion, clipped to one
        logic [15:0] w;     // prior weight
        logic        wz;    // weight is zero
    } t_job;

    // Rounded-up reciprocal 2^32/k for the small Horner divisors.
    function automatic logic [32:0] recip_small(input logic [2:0] k);
        logic [32:0] m;
        unique case (k)
            3'd1:    m = 33'h1_0000_0000;
            3'd2:    m = 33'd2147483648;
            3'd3:    m = 33'd1431655766;
            3'd4:    m = 33'd1073741824;
            3'd5:    m = 33'd858993460;
            3'd6:    m = 33'd715827883;
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

### hdl/blg_front.sv
// Front end: takes requests, classifies eta, clips the proportion, flags zero weight.
// Uses blg_pkg; feeds blg_queue.
module blg_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_eta,
    input  logic        [15:0] i_y_value,
    input  logic        [15:0] i_weight,
    input  logic               i_q_full,
    output logic               o_push,
    output blg_pkg::t_job      o_job
);

    logic          r_valid;
    blg_pkg::t_job r_job;
    blg_pkg::t_job n_job;
    logic [16:0]   neg_mag;

    assign neg_mag   = 17'h1_0000 - {1'b0, i_eta};
    assign n_job.neg = i_eta[15];
    assign n_job.mag = i_eta[15] ? neg_mag[15:0] : i_eta;
    assign n_job.y   = (i_y_value > blg_pkg::ONE_Q15) ? blg_pkg::ONE_Q15 : i_y_value;
    assign n_job.w   = i_weight;
    assign n_job.wz  = (i_weight == 16'd0);

    assign o_push  = r_valid && !i_q_full;
    assign o_ready = !r_valid || !i_q_full;
    assign o_job   = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_job <= n_job;
        end
    end

endmodule

### hdl/blg_queue.sv
// Short request queue between the front end and the arithmetic back end.
// Uses blg_pkg for the entry type.
module blg_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  blg_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output blg_pkg::t_job o_job
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    blg_pkg::t_job r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            unique case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + CW'(1);
                2'b01:   r_cnt <= r_cnt - CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

### hdl/blg_exp.sv
// Pipelined exp(-|eta|) in Q0.30: Horner series in x = |eta|/256, then eight squarings.
// Uses blg_pkg for step counts and reciprocals.
module blg_exp (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [15:0] i_mag,
    output logic [30:0] o_e
);

    localparam int unsigned NS = blg_pkg::EXP_STEPS;
    localparam int unsigned NQ = blg_pkg::SQ_STEPS;
    localparam logic [61:0] SQ_HALF = 62'd1 << 29;

    logic [26:0] r_xa [NS];
    logic [26:0] r_n  [NS];
    logic [26:0] r_xb [NS];
    logic [30:0] r_h  [NS];
    logic [30:0] r_sq [NQ];

    logic [26:0] x_in  [NS];
    logic [30:0] h_in  [NS];
    logic [57:0] prod  [NS];
    logic [59:0] quot  [NS];
    logic [30:0] n_h   [NS];
    logic [30:0] sq_in [NQ];
    logic [61:0] sq    [NQ];

    always_comb begin
        x_in[0] = {i_mag, 11'b0};
        h_in[0] = blg_pkg::ONE_Q30;
        for (int j = 1; j < NS; j++) begin
            x_in[j] = r_xb[j-1];
            h_in[j] = r_h[j-1];
        end
        for (int j = 0; j < NS; j++) begin
            // Rounded division by k * 2^30: shift out 2^30, then divide by k.
            prod[j] = 58'(x_in[j]) * 58'(h_in[j]) + (58'(NS - j) << 29);
            quot[j] = 60'(r_n[j]) * 60'(blg_pkg::recip_small(3'(NS - j)));
            n_h[j]  = ({3'b0, quot[j][59:32]} >= blg_pkg::ONE_Q30) ? '0
                    : blg_pkg::ONE_Q30 - 31'(quot[j][59:32]);
        end
        sq_in[0] = r_h[NS-1];
        for (int i = 1; i < NQ; i++) begin
            sq_in[i] = r_sq[i-1];
        end
        for (int i = 0; i < NQ; i++) begin
            sq[i] = 62'(sq_in[i]) * 62'(sq_in[i]) + SQ_HALF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < NS; j++) begin
                r_xa[j] <= x_in[j];
                r_n[j]  <= prod[j][56:30];
                r_xb[j] <= r_xa[j];
                r_h[j]  <= n_h[j];
            end
            for (int i = 0; i < NQ; i++) begin
                r_sq[i] <= sq[i][60:30];
            end
        end
    end

    assign o_e = r_sq[NQ-1];

endmodule

### hdl/blg_div.sv
// Pipelined restoring divider for the logistic: round(2^60 / den), den in [2^30, 2^31].
// Uses blg_pkg for the stage count.
module blg_div (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_den,
    output logic [30:0] o_quot
);

    localparam int unsigned NB = blg_pkg::DIV_BITS;
    // The numerator 2^60 + den/2 shifted down by 31 bits.
    localparam logic [31:0] REM0 = 32'h2000_0000;

    logic [31:0] r_den [NB];
    logic [31:0] r_rem [NB];
    logic [30:0] r_q   [NB];

    logic [31:0] den_in [NB];
    logic [31:0] rem_in [NB];
    logic [30:0] q_in   [NB];
    logic [32:0] trial  [NB];
    logic        ge     [NB];

    always_comb begin
        den_in[0] = i_den;
        rem_in[0] = REM0;
        q_in[0]   = '0;
        for (int s = 1; s < NB; s++) begin
            den_in[s] = r_den[s-1];
            rem_in[s] = r_rem[s-1];
            q_in[s]   = r_q[s-1];
        end
        for (int s = 0; s < NB; s++) begin
            // The low numerator bits are those of den/2.
            trial[s] = {rem_in[s], den_in[s][NB - s]};
            ge[s]    = (trial[s] >= {1'b0, den_in[s]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < NB; s++) begin
                r_den[s] <= den_in[s];
                r_rem[s] <= ge[s] ? 32'(trial[s] - {1'b0, den_in[s]}) : trial[s][31:0];
                r_q[s]   <= q_in[s] | (31'(ge[s]) << (NB - 1 - s));
            end
        end
    end

    assign o_quot = r_q[NB-1];

endmodule

### hdl/blg_lg2.sv
// Pipelined base-two logarithm of a 16-bit integer in Q.26, by repeated squaring.
// Uses blg_pkg for the fraction length.
module blg_lg2 (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [15:0] i_n,
    output logic [29:0] o_lg
);

    localparam int unsigned NF = blg_pkg::LG_FRAC;
    localparam int unsigned NL = blg_pkg::LAT_LG;

    logic [3:0]    r_p [NL];
    logic [30:0]   r_x [NL];
    logic [NF-1:0] r_f [NL];

    logic [3:0]  lead;
    logic [30:0] x0;
    logic [61:0] sq [NL];

    always_comb begin
        lead = '0;
        for (int b = 0; b < 16; b++) begin
            if (i_n[b]) begin
                lead = 4'(b);
            end
        end
        x0 = 31'(i_n) << (5'd30 - 5'(lead));
        sq[0] = '0;
        for (int s = 1; s < NL; s++) begin
            sq[s] = 62'(r_x[s-1]) * 62'(r_x[s-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p[0] <= lead;
            r_x[0] <= x0;
            r_f[0] <= '0;
            for (int s = 1; s < NL; s++) begin
                r_p[s] <= r_p[s-1];
                // A square of two or more yields a one bit and is halved.
                r_x[s] <= sq[s][61] ? sq[s][61:31] : sq[s][60:30];
                r_f[s] <= {r_f[s-1][NF-2:0], sq[s][61]};
            end
        end
    end

    assign o_lg = {r_p[NL-1], r_f[NL-1]};

endmodule

### hdl/blg_back.sv
// Back end: logistic, derivative, variance and weighted deviance in one stalling pipeline.
// Uses blg_pkg, blg_exp, blg_div and blg_lg2.
module blg_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  blg_pkg::t_job i_job,
    input  logic          i_job_valid,
    output logic          o_pop,
    input  logic          i_ready,
    output logic          o_valid,
    output logic [15:0]   o_mu,
    output logic [13:0]   o_mu_deriv,
    output logic [13:0]   o_variance_out,
    output logic [31:0]   o_deviance,
    output logic          o_mu_in_range,
    output logic          o_deviance_saturated
);

    localparam int unsigned SIDE_LEN  = blg_pkg::LAT_EXP + blg_pkg::DIV_BITS + 1;
    localparam int unsigned NL        = blg_pkg::LAT_LG;
    localparam int unsigned LAT_TOTAL = SIDE_LEN + NL + 4;

    typedef struct packed {
        logic        neg;
        logic [15:0] y;
        logic [15:0] w;
        logic        wz;
    } t_side;

    typedef struct packed {
        logic [15:0] m;
        logic [13:0] der;
        logic [13:0] vari;
        logic        inr;
        logic        inf;
        logic [15:0] y;
        logic [15:0] w;
        logic        wz;
    } t_mid;

    logic        en;
    logic        r_vld [LAT_TOTAL];
    t_side       r_sa  [SIDE_LEN];
    t_mid        r_md  [NL];
    logic [15:0] r_m;
    logic [15:0] r_mc;
    logic [61:0] r_sc;
    logic signed [47:0] r_p1;
    logic signed [47:0] r_p2;
    t_mid        r_m1;
    logic [31:0] r_n;
    t_mid        r_m2;
    logic [31:0] r_k;
    t_mid        r_m3;
    logic [15:0] r_mu;
    logic [13:0] r_der;
    logic [13:0] r_var;
    logic [31:0] r_dev;
    logic        r_inr;
    logic        r_sat;

    logic [30:0] e_val;
    logic [31:0] den;
    logic [30:0] quot;
    logic [30:0] s_cl;
    logic [30:0] c_val;
    logic [30:0] sig;
    logic [31:0] msum;
    logic [15:0] n_m;
    logic [15:0] y_p1;
    logic [15:0] yc_p1;
    logic [29:0] lg_y;
    logic [29:0] lg_yc;
    logic [29:0] lg_m;
    logic [29:0] lg_mc;
    logic [61:0] der_sum;
    logic [31:0] var_sum;
    t_mid        n_mid;
    t_mid        m_l;
    logic [15:0] yc_l;
    logic signed [30:0] d_y;
    logic signed [30:0] d_yc;
    logic signed [48:0] t_sum;
    logic [35:0] n_raw;
    logic [31:0] n_n;
    logic [64:0] k_sum;
    logic [48:0] dev_sum;

    assign o_valid = r_vld[LAT_TOTAL-1];
    assign en      = !o_valid || i_ready;
    assign o_pop   = en && i_job_valid;

    blg_exp u_exp (
        .i_clk (i_clk),
        .i_en  (en),
        .i_mag (i_job.mag),
        .o_e   (e_val)
    );

    assign den = 32'(blg_pkg::ONE_Q30) + 32'(e_val);

    blg_div u_div (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_den  (den),
        .o_quot (quot)
    );

    // Logistic and its complement, then the mean rounded to Q1.15.
    assign s_cl  = (quot > blg_pkg::ONE_Q30) ? blg_pkg::ONE_Q30 : quot;
    assign c_val = blg_pkg::ONE_Q30 - s_cl;
    assign sig   = r_sa[SIDE_LEN-2].neg ? c_val : s_cl;
    assign msum  = 32'(sig) + 32'h0000_4000;
    assign n_m   = msum[30:15];

    assign y_p1  = r_sa[SIDE_LEN-1].y;
    assign yc_p1 = blg_pkg::ONE_Q15 - y_p1;

    blg_lg2 u_lg_y  (.i_clk(i_clk), .i_en(en), .i_n(y_p1),  .o_lg(lg_y));
    blg_lg2 u_lg_yc (.i_clk(i_clk), .i_en(en), .i_n(yc_p1), .o_lg(lg_yc));
    blg_lg2 u_lg_m  (.i_clk(i_clk), .i_en(en), .i_n(r_m),   .o_lg(lg_m));
    blg_lg2 u_lg_mc (.i_clk(i_clk), .i_en(en), .i_n(r_mc),  .o_lg(lg_mc));

    always_comb begin
        der_sum    = r_sc + (62'd1 << 44);
        var_sum    = 32'(r_m) * 32'(r_mc) + 32'h0000_4000;
        n_mid.m    = r_m;
        n_mid.der  = der_sum[58:45];
        n_mid.vari = var_sum[28:15];
        n_mid.inr  = (r_m != 16'd0) && (r_m < blg_pkg::ONE_Q15);
        // A nonzero share of y where the mean sits on that bound is infinite.
        n_mid.inf  = ((y_p1 != 16'd0) && (r_m == 16'd0))
                   || ((yc_p1 != 16'd0) && (r_mc == 16'd0));
        n_mid.y    = y_p1;
        n_mid.w    = r_sa[SIDE_LEN-1].w;
        n_mid.wz   = r_sa[SIDE_LEN-1].wz;
    end

    // Terms with a zero share of y vanish through the product itself.
    assign m_l   = r_md[NL-1];
    assign yc_l  = blg_pkg::ONE_Q15 - m_l.y;
    assign d_y   = $signed({1'b0, lg_y}) - $signed({1'b0, lg_m});
    assign d_yc  = $signed({1'b0, lg_yc}) - $signed({1'b0, lg_mc});

    assign t_sum = 49'(r_p1) + 49'(r_p2) + 49'sd4096;
    assign n_raw = t_sum[48:13];
    assign n_n   = (r_p1 + r_p2 < 0) ? '0
                 : ((n_raw[35:32] != 4'd0) ? 32'hFFFF_FFFF : n_raw[31:0]);

    assign k_sum   = 65'(r_n) * 65'(blg_pkg::LN2_Q32) + (65'd1 << 31);
    assign dev_sum = 49'(r_m3.w) * 49'(r_k) + (49'd1 << 18);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LAT_TOTAL; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= i_job_valid;
            for (int i = 1; i < LAT_TOTAL; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
        if (en) begin
            r_sa[0].neg <= i_job.neg;
            r_sa[0].y   <= i_job.y;
            r_sa[0].w   <= i_job.w;
            r_sa[0].wz  <= i_job.wz;
            for (int i = 1; i < SIDE_LEN; i++) begin
                r_sa[i] <= r_sa[i-1];
            end
            r_m  <= n_m;
            r_mc <= blg_pkg::ONE_Q15 - n_m;
            r_sc <= 62'(s_cl) * 62'(c_val);
            r_md[0] <= n_mid;
            for (int i = 1; i < NL; i++) begin
                r_md[i] <= r_md[i-1];
            end
            r_p1 <= 48'($signed({1'b0, m_l.y})) * 48'(d_y);
            r_p2 <= 48'($signed({1'b0, yc_l})) * 48'(d_yc);
            r_m1 <= m_l;
            r_n  <= n_n;
            r_m2 <= r_m1;
            r_k  <= k_sum[63:32];
            r_m3 <= r_m2;
            r_mu  <= r_m3.m;
            r_der <= r_m3.der;
            r_var <= r_m3.vari;
            r_inr <= r_m3.inr;
            priority if (r_m3.wz) begin
                r_dev <= '0;
                r_sat <= 1'b0;
            end else if (r_m3.inf) begin
                r_dev <= 32'hFFFF_FFFF;
                r_sat <= 1'b1;
            end else begin
                r_dev <= 32'(dev_sum[48:19]);
                r_sat <= 1'b0;
            end
        end
    end

    assign o_mu                 = r_mu;
    assign o_mu_deriv           = r_der;
    assign o_variance_out       = r_var;
    assign o_deviance           = r_dev;
    assign o_mu_in_range        = r_inr;
    assign o_deviance_saturated = r_sat;

endmodule

### hdl/binomial_logit_glm_element.sv
// Binomial GLM element with logit link. Each request carries eta (signed Q5.11), a proportion
// y (Q1.15, values above one are taken as one) and a prior weight (Q8.8); each result gives mu,
// dmu/deta, the variance mu(1-mu), the weighted unit deviance in Q16.16 (all ones and a flag
// when mu sits on a bound that y has weight against, zero when the weight is zero) and a flag
// for mu strictly inside (0,1). One request is taken per clock and one result leaves per clock
// while the output is not stalled; each result passes through a deep arithmetic pipeline:
// 20 stages of exponential, 31 stages of one-bit-per-stage division for the logistic,
// 27 stages of logarithm by repeated squaring, and the deviance and output stages. A stall at
// the output freezes the whole pipeline; the front register and the request queue then take
// up to QUEUE_DEPTH + 1 further requests before the input side stalls as well.
// Depends on blg_pkg, blg_front, blg_queue and blg_back.
module binomial_logit_glm_element #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_eta,
    input  logic        [15:0] i_y_value,
    input  logic        [15:0] i_weight,
    output logic               o_valid,
    input  logic               i_ready,
    output logic        [15:0] o_mu,
    output logic        [13:0] o_mu_deriv,
    output logic        [13:0] o_variance_out,
    output logic        [31:0] o_deviance,
    output logic               o_mu_in_range,
    output logic               o_deviance_saturated
);

    blg_pkg::t_job front_job;
    blg_pkg::t_job queue_job;
    logic          push;
    logic          full;
    logic          empty;
    logic          pop;

    blg_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_eta     (i_eta),
        .i_y_value (i_y_value),
        .i_weight  (i_weight),
        .i_q_full  (full),
        .o_push    (push),
        .o_job     (front_job)
    );

    blg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_job   (queue_job)
    );

    blg_back u_back (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_job                (queue_job),
        .i_job_valid          (!empty),
        .o_pop                (pop),
        .i_ready              (i_ready),
        .o_valid              (o_valid),
        .o_mu                 (o_mu),
        .o_mu_deriv           (o_mu_deriv),
        .o_variance_out       (o_variance_out),
        .o_deviance           (o_deviance),
        .o_mu_in_range        (o_mu_in_range),
        .o_deviance_saturated (o_deviance_saturated)
    );

endmodule

### hdl/blg_checker.sv
// Port-level checks on the binomial logit GLM element, bound to the top level.
// Depends only on the top level's ports.
module blg_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_ready,
    input logic        [15:0] o_mu,
    input logic        [13:0] o_variance_out,
    input logic        [31:0] o_deviance,
    input logic               o_mu_in_range,
    input logic               o_deviance_saturated
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_mu) && $stable(o_deviance)
            && $stable(o_deviance_saturated))
        else $error("result changed while stalled");

    a_range_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_mu_in_range == ((o_mu != 16'd0) && (o_mu < 16'h8000)))
        else $error("range flag disagrees with mu");

    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_deviance_saturated |-> o_deviance == 32'hFFFF_FFFF)
        else $error("saturation flag without full-scale deviance");

    a_bound_var: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && ((o_mu == 16'd0) || (o_mu == 16'h8000)) |-> o_variance_out == 14'd0)
        else $error("nonzero variance with mu on a bound");

    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid straight after reset");

endmodule

bind binomial_logit_glm_element blg_checker u_blg_checker (.*);

### test/tb_top.sv
// Self-checking bench for binomial_logit_glm_element: a table of directed requests, then random
// requests under several idling phases, each result checked against its typed row or a bit-exact predictor.
// Depends on blg_pkg and the RTL of the block only.
`timescale 1ns / 100ps

module tb_top;

    typedef struct packed {
        logic [15:0] mu;
        logic [13:0] deriv;
        logic [13:0] vari;
        logic [31:0] dev;
        logic        in_range;
        logic        sat;
    } t_glm_res;

    typedef struct {
        logic [15:0] eta;
        logic [15:0] y;
        logic [15:0] w;
        bit          typed;
        t_glm_res    res;
    } t_row;

    localparam int N_RANDOM = 1230;
    localparam int WATCHDOG = 3000;
    localparam int LONG_HOLD = 300;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic signed [15:0] i_eta = '0;
    logic        [15:0] i_y_value = '0;
    logic        [15:0] i_weight = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic        [15:0] o_mu;
    logic        [13:0] o_mu_deriv;
    logic        [13:0] o_variance_out;
    logic        [31:0] o_deviance;
    logic               o_mu_in_range;
    logic               o_deviance_saturated;

    t_glm_res pending_q[$];
    int       errors = 0;
    int       idle_cycles = 0;
    int       send_idle_pct = 0;
    int       stall_pct = 0;
    bit       hold_req = 1'b0;

    binomial_logit_glm_element DUT (.*);

    always #5 i_clk = ~i_clk;

    // Base-two logarithm in Q.26 by repeated squaring.
    function automatic longint unsigned log2_q26(input longint unsigned n);
        longint unsigned p, x, frac;
        p = 0;
        frac = 0;
        if (n == 0) return 0;
        while (p < 31 && (n >> (p + 1)) != 0) p++;
        x = ((n << (30 - p)) & 64'h7FFF_FFFF) | (64'd1 << 30);
        for (int i = 0; i < 26; i++) begin
            x = (x * x) >> 30;
            if (x >= (64'd1 << 31)) begin
                x >>= 1;
                frac |= 64'd1 << (25 - i);
            end
        end
        return (p << 26) | frac;
    endfunction

    function automatic t_glm_res glm_element(input logic [15:0] eta, input logic [15:0] yv,
                                            input logic [15:0] wv);
        t_glm_res r;
        longint unsigned a, x, h, d, t, e, den, s, c, sig, m, mc, y, yc, n, k, dv;
        longint signed   tt;
        bit neg, inf, sat;
        neg = eta[15];
        a = neg ? (64'h10000 - eta) : eta;
        x = a << 11;
        h = 64'd1 << 30;
        for (int kk = 6; kk >= 1; kk--) begin
            d = kk * (64'd1 << 30);
            t = (x * h + d / 2) / d;
            h = (t >= (64'd1 << 30)) ? 0 : (64'd1 << 30) - t;
        end
        for (int i = 0; i < 8; i++) h = (h * h + (64'd1 << 29)) >> 30;
        e = h;
        den = (64'd1 << 30) + e;
        s = ((64'd1 << 60) + den / 2) / den;
        if (s > (64'd1 << 30)) s = 64'd1 << 30;
        c = (64'd1 << 30) - s;
        sig = neg ? c : s;
        m = (sig + (64'd1 << 14)) >> 15;
        mc = 32768 - m;
        r.mu = m[15:0];
        r.deriv = 14'((s * c + (64'd1 << 44)) >> 45);
        r.vari = 14'((m * mc + (64'd1 << 14)) >> 15);
        y = (yv > 16'd32768) ? 32768 : yv;
        yc = 32768 - y;
        inf = (y > 0 && m == 0) || (yc > 0 && mc == 0);
        sat = 1'b0;
        dv = 0;
        if (wv == 0) begin
            dv = 0;
        end else if (inf) begin
            dv = 64'hFFFF_FFFF;
            sat = 1'b1;
        end else begin
            tt = 0;
            if (y > 0) tt += longint'(y) * (longint'(log2_q26(y)) - longint'(log2_q26(m)));
            if (yc > 0) tt += longint'(yc) * (longint'(log2_q26(yc)) - longint'(log2_q26(mc)));
            if (tt < 0) tt = 0;
            n = (unsigned'(tt) + (64'd1 << 12)) >> 13;
            if (n > 64'hFFFF_FFFF) n = 64'hFFFF_FFFF;
            k = (n * 64'd2977044472 + (64'd1 << 31)) >> 32;
            dv = (64'(wv) * k + (64'd1 << 18)) >> 19;
            if (dv > 64'hFFFF_FFFF) begin
                dv = 64'hFFFF_FFFF;
                sat = 1'b1;
            end
        end
        r.dev = dv[31:0];
        r.in_range = (m > 0 && m < 32768);
        r.sat = sat;
        return r;
    endfunction

    // Hands one request over and records its expected result on acceptance.
    task automatic send_request(input logic [15:0] eta, input logic [15:0] yv,
                                input logic [15:0] wv, input bit typed, input t_glm_res res);
        bit acc;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_eta <= eta;
        i_y_value <= yv;
        i_weight <= wv;
        do begin
            @(negedge i_clk);
            acc = i_valid && o_ready;
            if (acc) pending_q.push_back(typed ? res : glm_element(eta, yv, wv));
            @(posedge i_clk);
        end while (!acc);
    endtask

    task automatic set_phase(input int s_pct, input int r_pct);
        i_valid <= 1'b0;
        @(posedge i_clk);
        send_idle_pct = s_pct;
        stall_pct = r_pct;
    endtask

    // Receiver: random stalls, plus one long hold-off when asked.
    initial begin
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                for (int i = 0; i < LONG_HOLD; i++) begin
                    i_ready <= 1'b0;
                    @(posedge i_clk);
                end
                hold_req = 1'b0;
            end
            i_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(negedge i_clk) begin
        t_glm_res got, want;
        if (i_rst_n && o_valid && i_ready) begin
            got = '{o_mu, o_mu_deriv, o_variance_out, o_deviance, o_mu_in_range,
                    o_deviance_saturated};
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end else begin
                want = pending_q.pop_front();
                if (got.mu != want.mu)
                    $display("%0t: mu exp %0d got %0d", $time, want.mu, got.mu);
                if (got.deriv != want.deriv)
                    $display("%0t: mu_deriv exp %0d got %0d", $time, want.deriv, got.deriv);
                if (got.vari != want.vari)
                    $display("%0t: variance exp %0d got %0d", $time, want.vari, got.vari);
                if (got.dev != want.dev)
                    $display("%0t: deviance exp %h got %h", $time, want.dev, got.dev);
                if (got.in_range != want.in_range)
                    $display("%0t: mu_in_range exp %b got %b", $time, want.in_range,
                             got.in_range);
                if (got.sat != want.sat)
                    $display("%0t: saturated exp %b got %b", $time, want.sat, got.sat);
                if (got != want) errors++;
            end
        end
    end

    // Watchdog on cycles in which neither side moves a request or result.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG) begin
            $display("tb_top NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        t_row rows[$];
        t_glm_res none;
        logic [15:0] eta, yv, wv;
        none = '0;
        // Extremes, the bounds of mu, weight zero, proportions above one.
        rows = '{
            '{16'h0000, 16'd16384, 16'h0100, 1, '{16'd16384, 14'd8192, 14'd8192, 32'd0, 1, 0}},
            '{16'h8000, 16'd32768, 16'h0001, 1, '{16'd0, 14'd0, 14'd0, 32'hFFFF_FFFF, 0, 1}},
            '{16'h8000, 16'd32768, 16'h0000, 1, '{16'd0, 14'd0, 14'd0, 32'd0, 0, 0}},
            '{16'h8000, 16'd0, 16'hFFFF, 1, '{16'd0, 14'd0, 14'd0, 32'd0, 0, 0}},
            '{16'h7FFF, 16'd0, 16'hFFFF, 1, '{16'd32768, 14'd0, 14'd0, 32'hFFFF_FFFF, 0, 1}},
            '{16'h7FFF, 16'hFFFF, 16'h0100, 1, '{16'd32768, 14'd0, 14'd0, 32'd0, 0, 0}},
            '{16'h7FFF, 16'd32768, 16'h0000, 0, none},
            '{16'h0000, 16'd0, 16'hFFFF, 0, none},
            '{16'h0000, 16'd32768, 16'hFFFF, 0, none},
            '{16'h0000, 16'hFFFF, 16'h0100, 0, none},
            '{16'h0001, 16'd1, 16'h0100, 0, none},
            '{16'hFFFF, 16'd32767, 16'h0100, 0, none},
            '{16'h1000, 16'd100, 16'hFFFF, 0, none},
            '{16'hF000, 16'd32700, 16'hFFFF, 0, none},
            '{16'h4000, 16'd0, 16'h8000, 0, none},
            '{16'hC000, 16'd1, 16'h8000, 0, none},
            '{16'h5800, 16'd1, 16'hFFFF, 0, none},
            '{16'hA800, 16'd32767, 16'hFFFF, 0, none},
            '{16'h2000, 16'h8001, 16'h0001, 0, none},
            '{16'h0800, 16'h5555, 16'hAAAA, 0, none}
        };
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (rows[i])
            send_request(rows[i].eta, rows[i].y, rows[i].w, rows[i].typed, rows[i].res);
        for (int i = 0; i < N_RANDOM; i++) begin
            case (i)
                0:    set_phase(0, 0);
                250:  begin set_phase(45, 0); hold_req = 1'b1; end
                500:  set_phase(0, 45);
                750:  begin
                          set_phase(16, 16);
                          wait (pending_q.size() == 0);
                          @(posedge i_clk);
                      end
                1000: set_phase(0, 0);
                default: ;
            endcase
            // Mostly moderate eta, where mu is not pinned to a bound.
            eta = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($signed($urandom_range(12000))
                  - 16'sd6000);
            yv = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(32768));
            wv = ($urandom_range(15) == 0) ? 16'($urandom_range(1)) : 16'($urandom);
            send_request(eta, yv, wv, 0, none);
        end
        i_valid <= 1'b0;
        wait (pending_q.size() == 0);
        repeat (100) @(posedge i_clk);
        if (errors == 0 && pending_q.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end
endmodule

### binomial_logit_glm_element.f
hdl/blg_pkg.sv
hdl/blg_front.sv
hdl/blg_queue.sv
hdl/blg_exp.sv
hdl/blg_div.sv
hdl/blg_lg2.sv
hdl/blg_back.sv
hdl/binomial_logit_glm_element.sv
hdl/blg_checker.sv
test/tb_top.sv
